[design/tskf_pkg.sv]
// shared types, constants and filter coefficients for the keyed carrier fir
`timescale 1ns / 1ps

package tskf_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int CONFIG_WIDTH   = 24;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 32;
   localparam int PRODUCT_BITS   = 32;
   localparam int COEF_COUNT     = 32;
   localparam int OUT_SHIFT      = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CARRIER_INCREMENT = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SECOND_INCREMENT  = 4'd1;

   localparam logic [CONFIG_WIDTH-1:0] SECOND_INCREMENT_RESET = 24'd349;

   localparam logic signed [1:0] SYM_SHORT = 2'sb00;
   localparam logic signed [1:0] SYM_LONG  = 2'sb01;
   localparam logic signed [1:0] SYM_LATE  = 2'sb11;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   localparam sample_type COEF_TABLE [COEF_COUNT] = '{
      16'sd465,   16'sd48,    -16'sd33,   -16'sd1295, -16'sd736,  16'sd221,   -16'sd503,
      -16'sd1930, -16'sd2095, -16'sd684,  16'sd101,   -16'sd1922, -16'sd4702, -16'sd3117,
      16'sd4111,  16'sd11188, 16'sd11188, 16'sd4111,  -16'sd3117, -16'sd4702, -16'sd1922,
      16'sd101,   -16'sd684,  -16'sd2095, -16'sd1930, -16'sd503,  16'sd221,   -16'sd736,
      -16'sd1295, -16'sd33,   16'sd48,    16'sd465
   };

   typedef struct packed {
      logic signed [1:0] next_symbol;
      logic              last_in_block;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          carrier_gated;
      logic                          block_end;
   } rsp_word_type;

   typedef struct packed {
      sample_type sample;
      logic       gated;
   } key_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MAC,
      ST_DRAIN,
      ST_RESULT
   } fir_state_type;

   // taps past the table weigh zero
   function automatic sample_type coef_at(input int unsigned idx);
      sample_type value;
      value = '0;
      if (idx < COEF_COUNT) begin
         value = COEF_TABLE[idx[4:0]];
      end
      return value;
   endfunction

endpackage

[design/tskf_cell.sv]
// one delay line cell: holds a sample and hands it to its neighbor on shift
`timescale 1ns / 1ps

module tskf_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  tskf_pkg::sample_type data_in,
   output tskf_pkg::sample_type data_out
);

   tskf_pkg::sample_type sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (shift_en) begin
         sample_ff <= data_in;
      end
   end

   assign data_out = sample_ff;

endmodule

[design/tskf_keyer.sv]
// carrier and second phase accumulators, symbol keying and cosine rom
`timescale 1ns / 1ps

module tskf_keyer #(
   parameter int PHASE_BITS     = 24,
   parameter int COS_INDEX_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step,
   input  logic signed [1:0]                     next_symbol,
   input  logic [tskf_pkg::CONFIG_WIDTH-1:0]     carrier_increment,
   input  logic [tskf_pkg::CONFIG_WIDTH-1:0]     second_increment,
   output tskf_pkg::key_word_type                key_out
);

   localparam int ROM_SIZE = 1 << COS_INDEX_BITS;
   localparam real ANGLE_STEP = 2.0 * 3.14159265358979323846 / ROM_SIZE;
   localparam int SUM_BITS =
      (PHASE_BITS > tskf_pkg::CONFIG_WIDTH ? PHASE_BITS : tskf_pkg::CONFIG_WIDTH) + 1;
   localparam logic [SUM_BITS-1:0] FULL = SUM_BITS'(1) << PHASE_BITS;
   localparam logic [PHASE_BITS-1:0] BOUND_1 = PHASE_BITS'((64'd1 << PHASE_BITS) * 1 / 10);
   localparam logic [PHASE_BITS-1:0] BOUND_2 = PHASE_BITS'((64'd1 << PHASE_BITS) * 2 / 10);
   localparam logic [PHASE_BITS-1:0] BOUND_3 = PHASE_BITS'((64'd1 << PHASE_BITS) * 3 / 10);
   localparam logic [PHASE_BITS-1:0] BOUND_4 = PHASE_BITS'((64'd1 << PHASE_BITS) * 4 / 10);

   typedef tskf_pkg::sample_type rom_type [ROM_SIZE];

   function automatic rom_type build_rom();
      rom_type rom;
      real     angle;
      int      i;
      for (i = 0; i < ROM_SIZE; i++) begin
         angle  = ANGLE_STEP * real'(i);
         rom[i] = tskf_pkg::SAMPLE_BITS'(int'(32767.0 * $cos(angle)));
      end
      return rom;
   endfunction

   localparam rom_type COS_ROM = build_rom();

   logic [PHASE_BITS-1:0]     carrier_phase_ff, carrier_phase_in;
   logic [PHASE_BITS-1:0]     second_phase_ff, second_phase_in;
   logic signed [1:0]         symbol_ff, symbol_in;
   logic                      gated_ff, gated_in;
   tskf_pkg::sample_type      rom_data_ff;
   logic [SUM_BITS-1:0]       carrier_sum, second_sum;
   logic [COS_INDEX_BITS-1:0] rom_addr;
   logic                      wrap;

   always_comb begin
      carrier_sum      = SUM_BITS'(carrier_phase_ff) + SUM_BITS'(carrier_increment);
      second_sum       = SUM_BITS'(second_phase_ff) + SUM_BITS'(second_increment);
      wrap             = second_sum >= FULL;
      carrier_phase_in = carrier_sum[PHASE_BITS-1:0];
      second_phase_in  = second_sum[PHASE_BITS-1:0];
      symbol_in        = wrap ? next_symbol : symbol_ff;
      rom_addr         = carrier_phase_ff[PHASE_BITS-1 -: COS_INDEX_BITS];
      gated_in         = (symbol_ff == tskf_pkg::SYM_SHORT && second_phase_ff < BOUND_1)
                      || (symbol_ff == tskf_pkg::SYM_LONG && second_phase_ff < BOUND_2)
                      || (symbol_ff == tskf_pkg::SYM_LATE && second_phase_ff > BOUND_3
                          && second_phase_ff < BOUND_4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_phase_ff <= '0;
         second_phase_ff  <= '0;
         symbol_ff        <= tskf_pkg::SYM_SHORT;
      end else if (step) begin
         carrier_phase_ff <= carrier_phase_in;
         second_phase_ff  <= second_phase_in;
         symbol_ff        <= symbol_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rom_data_ff <= COS_ROM[rom_addr];
         gated_ff    <= gated_in;
      end
   end

   assign key_out.sample = gated_ff ? tskf_pkg::sample_type'(0) : rom_data_ff;
   assign key_out.gated  = gated_ff;

endmodule

[design/time_signal_keyed_carrier_fir.sv]
// top level: keyed carrier source feeding a delay line ring with one shared mac
`timescale 1ns / 1ps

//  channel | direction | handshake          | payload
//  req     | in        | req_valid/ready    | req_word (next_symbol, last_in_block)
//  rsp     | out       | rsp_valid/ready    | rsp_word (sample_out, carrier_gated, block_end)
//  csr     | in        | csr_valid/ready    | csr_index, csr_data (always ready)
//
//  each word passes through a rom read, a ring load, one ring rotation per tap
//  through the shared multiplier, an accumulator drain and a result write
//  req_ready is high only between words; the result register frees the filter
//  as soon as it is loaded, so a stalled rsp holds the next word in its result write
//  synchronous reset clears phases, symbol and the delay line cells

module time_signal_keyed_carrier_fir #(
   parameter int TAPS           = 32,
   parameter int PHASE_BITS     = 24,
   parameter int COS_INDEX_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  tskf_pkg::req_word_type                req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output tskf_pkg::rsp_word_type                rsp_word,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tskf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tskf_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int CNT_BITS = $clog2(TAPS);

   logic [tskf_pkg::CONFIG_WIDTH-1:0]     carrier_increment_ff, second_increment_ff;
   tskf_pkg::fir_state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]                   tap_cnt_ff, tap_cnt_in;
   logic signed [tskf_pkg::PRODUCT_BITS-1:0] product_ff, product_in;
   logic signed [tskf_pkg::PRODUCT_BITS-1:0] acc_ff, acc_in;
   logic                                  prod_valid_ff;
   logic                                  block_end_ff, gated_ff;
   logic                                  rsp_valid_ff;
   tskf_pkg::rsp_word_type                rsp_word_ff;
   tskf_pkg::key_word_type                key;
   tskf_pkg::sample_type                  cell_data [TAPS];
   tskf_pkg::sample_type                  head_in;
   logic                                  step, shift_en, load, mac, emit;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_increment_ff <= '0;
         second_increment_ff  <= tskf_pkg::SECOND_INCREMENT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            tskf_pkg::CSR_CARRIER_INCREMENT:
               carrier_increment_ff <= csr_data[tskf_pkg::CONFIG_WIDTH-1:0];
            tskf_pkg::CSR_SECOND_INCREMENT:
               second_increment_ff <= csr_data[tskf_pkg::CONFIG_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ready = (state_ff == tskf_pkg::ST_IDLE);
   assign step      = req_valid && req_ready;

   tskf_keyer #(
      .PHASE_BITS     (PHASE_BITS),
      .COS_INDEX_BITS (COS_INDEX_BITS)
   ) u_keyer (
      .clock             (clock),
      .reset             (reset),
      .step              (step),
      .next_symbol       (req_word.next_symbol),
      .carrier_increment (carrier_increment_ff),
      .second_increment  (second_increment_ff),
      .key_out           (key)
   );

   always_comb begin
      state_in = state_ff;
      load     = 1'b0;
      mac      = 1'b0;
      emit     = 1'b0;
      unique case (state_ff)
         tskf_pkg::ST_IDLE: begin
            if (step) state_in = tskf_pkg::ST_LOAD;
         end
         tskf_pkg::ST_LOAD: begin
            load     = 1'b1;
            state_in = tskf_pkg::ST_MAC;
         end
         tskf_pkg::ST_MAC: begin
            mac = 1'b1;
            if (tap_cnt_ff == CNT_BITS'(TAPS - 1)) state_in = tskf_pkg::ST_DRAIN;
         end
         tskf_pkg::ST_DRAIN: begin
            state_in = tskf_pkg::ST_RESULT;
         end
         tskf_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               emit     = 1'b1;
               state_in = tskf_pkg::ST_IDLE;
            end
         end
         default: state_in = tskf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tskf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ring: load shifts the new sample in, mac rotates the oldest tap back to the head
   assign shift_en = load || mac;
   assign head_in  = load ? key.sample : cell_data[TAPS-1];

   for (genvar k = 0; k < TAPS; k++) begin : g_cell
      tskf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .data_in  ((k == 0) ? head_in : cell_data[(k == 0) ? 0 : k - 1]),
         .data_out (cell_data[k])
      );
   end

   always_comb begin
      tap_cnt_in = load ? '0 : (mac ? tap_cnt_ff + CNT_BITS'(1) : tap_cnt_ff);
      product_in = tskf_pkg::PRODUCT_BITS'(cell_data[TAPS-1]) *
                   tskf_pkg::PRODUCT_BITS'(tskf_pkg::coef_at(32'(tap_cnt_ff)));
      acc_in     = load ? '0 : (prod_valid_ff ? acc_ff + product_ff : acc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= mac;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      tap_cnt_ff <= tap_cnt_in;
      acc_ff     <= acc_in;
      if (mac) product_ff <= product_in;
      if (step) block_end_ff <= req_word.last_in_block;
      if (load) gated_ff <= key.gated;
      if (emit) begin
         rsp_word_ff.sample_out    <= acc_ff[tskf_pkg::OUT_SHIFT +: tskf_pkg::SAMPLE_BITS];
         rsp_word_ff.carrier_gated <= gated_ff;
         rsp_word_ff.block_end     <= block_end_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[tb/tskf_sample_checker.sv]
// checker for the keyed carrier fir: watches all channels, predicts each sample and compares
`timescale 1ns / 1ps

module tskf_sample_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  tskf_pkg::req_word_type              req_word,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  tskf_pkg::rsp_word_type              rsp_word,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [tskf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tskf_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                  error_count,
   output int                                  pending,
   output int                                  checked_count,
   output int                                  gated_count
);

   import tskf_pkg::*;

   localparam int          TAPS           = 32;
   localparam int          PHASE_BITS     = 24;
   localparam int          COS_INDEX_BITS = 10;
   localparam int          ROM_SIZE       = 1 << COS_INDEX_BITS;
   localparam int          QUARTER        = ROM_SIZE / 4;
   localparam int unsigned PHASE_FULL     = 1 << PHASE_BITS;
   localparam int unsigned SHORT_END      = PHASE_FULL * 1 / 10;
   localparam int unsigned LONG_END       = PHASE_FULL * 2 / 10;
   localparam int unsigned LATE_START     = PHASE_FULL * 3 / 10;
   localparam int unsigned LATE_END       = PHASE_FULL * 4 / 10;
   localparam logic [63:0] Q62_ONE        = 64'd1 << 62;
   localparam logic [63:0] ANGLE_STEP     = 64'h6487ED5110B4611A >> (COS_INDEX_BITS - 2);

   sample_type              cos_table [ROM_SIZE];
   logic [PHASE_BITS-1:0]   carrier_step;
   logic [PHASE_BITS-1:0]   second_step;
   logic [PHASE_BITS-1:0]   carrier_phase;
   logic [PHASE_BITS-1:0]   second_phase;
   logic signed [1:0]       keying_symbol;
   sample_type              sample_ring [TAPS];
   logic [4:0]              ring_pointer;
   rsp_word_type            expected_samples [$];
   int                      accepted_count = 0;

   assign pending = accepted_count - checked_count;

   initial begin
      error_count   = 0;
      checked_count = 0;
      gated_count   = 0;
   end

   // (a*b) >> 62 in q62
   function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] wide;
      wide = {64'd0, a} * {64'd0, b};
      return wide[125:62];
   endfunction

   function automatic logic [63:0] q62_series(input logic [63:0] x, input bit want_sin);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] divisor;
      x2   = q62_product(x, x);
      term = want_sin ? x : Q62_ONE;
      acc  = term;
      for (int n = 1; n <= 12; n++) begin
         divisor = want_sin ? 64'(2 * n * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
         term    = q62_product(term, x2) / divisor;
         if (n % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      return acc;
   endfunction

   function automatic int quarter_amplitude(input int r, input bit want_sin);
      logic [63:0] v;
      int          rr;
      bit          use_sin;
      rr      = r;
      use_sin = want_sin;
      if (rr > QUARTER / 2) begin
         rr      = QUARTER - rr;
         use_sin = !use_sin;
      end
      v = q62_series(ANGLE_STEP * 64'(rr), use_sin);
      return int'(((v >> 20) * 64'd32767 + (64'd1 << 41)) >> 42);
   endfunction

   initial begin
      int amp;
      for (int i = 0; i < ROM_SIZE; i++) begin
         case (i / QUARTER)
            0: begin
               amp = quarter_amplitude(i % QUARTER, 1'b0);
            end
            1: begin
               amp = -quarter_amplitude(i % QUARTER, 1'b1);
            end
            2: begin
               amp = -quarter_amplitude(i % QUARTER, 1'b0);
            end
            default: begin
               amp = quarter_amplitude(i % QUARTER, 1'b1);
            end
         endcase
         cos_table[i] = sample_type'(amp);
      end
   end

   task automatic next_keyed_sample(input req_word_type w, output rsp_word_type r);
      logic                  off;
      sample_type            sample;
      longint                acc;
      logic [4:0]            ci;
      logic [PHASE_BITS:0]   second_sum;
      off = (second_phase < SHORT_END && keying_symbol == SYM_SHORT) ||
            (second_phase < LONG_END && keying_symbol == SYM_LONG) ||
            (second_phase > LATE_START && second_phase < LATE_END &&
             keying_symbol == SYM_LATE);
      sample = off ? sample_type'(0)
                   : cos_table[carrier_phase[PHASE_BITS-1 -: COS_INDEX_BITS]];
      sample_ring[ring_pointer] = sample;
      ring_pointer = ring_pointer + 5'd1;
      acc = 0;
      for (int u = 0; u < TAPS; u++) begin
         ci  = 5'(u) - ring_pointer;
         acc = acc + longint'(COEF_TABLE[ci]) * longint'(sample_ring[u]);
      end
      carrier_phase = carrier_phase + carrier_step;
      second_sum    = {1'b0, second_phase} + {1'b0, second_step};
      second_phase  = second_sum[PHASE_BITS-1:0];
      if (second_sum[PHASE_BITS]) begin
         keying_symbol = w.next_symbol;
      end
      r.sample_out    = acc[31:16];
      r.carrier_gated = off;
      r.block_end     = w.last_in_block;
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type made;
      if (reset) begin
         carrier_step  = '0;
         second_step   = SECOND_INCREMENT_RESET;
         carrier_phase = '0;
         second_phase  = '0;
         keying_symbol = SYM_SHORT;
         ring_pointer  = '0;
         for (int u = 0; u < TAPS; u++) begin
            sample_ring[u] = '0;
         end
         expected_samples.delete();
         accepted_count <= 0;
         checked_count  <= 0;
         gated_count    <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CARRIER_INCREMENT) begin
               carrier_step = csr_data[PHASE_BITS-1:0];
            end else if (csr_index == CSR_SECOND_INCREMENT) begin
               second_step = csr_data[PHASE_BITS-1:0];
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               if (error_count < 10) begin
                  $display("unexpected sample %0d gated %0b end %0b",
                           rsp_word.sample_out, rsp_word.carrier_gated, rsp_word.block_end);
               end
               error_count <= error_count + 1;
            end else begin
               want = expected_samples.pop_front();
               checked_count <= checked_count + 1;
               if (want.sample_out !== rsp_word.sample_out ||
                   want.carrier_gated !== rsp_word.carrier_gated ||
                   want.block_end !== rsp_word.block_end) begin
                  if (error_count < 10) begin
                     $display("mismatch at word %0d: ", checked_count,
                              "expected sample %0d gated %0b end %0b, ",
                              want.sample_out, want.carrier_gated, want.block_end,
                              "got sample %0d gated %0b end %0b",
                              rsp_word.sample_out, rsp_word.carrier_gated, rsp_word.block_end);
                  end
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            next_keyed_sample(req_word, made);
            expected_samples.push_back(made);
            accepted_count <= accepted_count + 1;
            if (made.carrier_gated) begin
               gated_count <= gated_count + 1;
            end
         end
      end
   end

endmodule

[tb/time_signal_keyed_carrier_fir_tb.sv]
// testbench top for the keyed carrier fir: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module time_signal_keyed_carrier_fir_tb;

   import tskf_pkg::*;

   localparam int          TAPS          = 32;
   localparam int          LIMIT         = 1000000;
   localparam int          IDLE_PERCENT  = 37;
   localparam int          MAX_GAP       = 80;
   localparam int          RANDOM_PHASES = 8;
   localparam int          PHASE_ITEMS   = 131;
   localparam int          SETTLE        = TAPS + 8;
   localparam int unsigned SECOND_FULL   = 1 << 24;
   localparam logic [31:0] INCREMENT_MAX = 32'h00FF_FFFF;
   localparam logic signed [1:0] SYM_INVALID = 2'sb10;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_UNUSED = CSR_SECOND_INCREMENT + 1'b1;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_word_type               req_word  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_word_type               rsp_word;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0]   csr_data  = '0;
   logic                       steady    = 1'b0;

   int error_count;
   int pending;
   int checked_count;
   int gated_count;
   int cycle_count   = 0;
   int sent_count    = 0;
   int setting_count = 0;

   time_signal_keyed_carrier_fir u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   tskf_sample_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending       (pending),
      .checked_count (checked_count),
      .gated_count   (gated_count)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("time_signal_keyed_carrier_fir test failed");
         $finish;
      end
   end

   function automatic req_word_type make_sample(input logic signed [1:0] sym, input logic last);
      req_word_type w;
      w.next_symbol   = sym;
      w.last_in_block = last;
      return w;
   endfunction

   function automatic req_word_type random_sample();
      logic signed [1:0] sym;
      if ($urandom_range(19) == 0) begin
         sym = SYM_INVALID;
      end else begin
         case ($urandom_range(2))
            0: begin
               sym = SYM_SHORT;
            end
            1: begin
               sym = SYM_LONG;
            end
            default: begin
               sym = SYM_LATE;
            end
         endcase
      end
      return make_sample(sym, $urandom_range(7) == 0);
   endfunction

   task automatic send_sample(input req_word_type w);
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      sent_count++;
      if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(MAX_GAP, 1)) @(posedge clock);
      end
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
   endtask

   // upper data bits and unused indexes must be ignored
   task automatic configure(input logic [31:0] carrier_inc, input logic [31:0] second_inc);
      write_register(CSR_CARRIER_INCREMENT, {8'($urandom), carrier_inc[23:0]});
      write_register(CSR_SECOND_INCREMENT, {8'($urandom), second_inc[23:0]});
      if ($urandom_range(1) == 0) begin
         write_register(4'($urandom_range(15, int'(CSR_FIRST_UNUSED))), $urandom);
      end
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      logic [31:0] carrier_inc;
      logic [31:0] second_inc;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings, symbol zero keys off the start of the second
      send_sample(make_sample(SYM_LONG, 1'b0));
      send_sample(make_sample(SYM_LATE, 1'b1));
      send_sample(make_sample(SYM_SHORT, 1'b0));
      drain();

      // both increments at full scale, second wraps almost every word
      configure(INCREMENT_MAX, INCREMENT_MAX);
      send_sample(make_sample(SYM_LATE, 1'b1));
      send_sample(make_sample(SYM_SHORT, 1'b0));
      send_sample(make_sample(SYM_LONG, 1'b1));
      send_sample(make_sample(SYM_INVALID, 1'b0));
      send_sample(make_sample(SYM_LATE, 1'b1));
      send_sample(make_sample(SYM_SHORT, 1'b1));
      drain();

      // eight words per second: long gap then late gap
      configure(32'h5A12_3456, SECOND_FULL / 8);
      for (int i = 0; i < 8; i++) begin
         send_sample(make_sample(SYM_LONG, i == 7));
      end
      for (int i = 0; i < 8; i++) begin
         send_sample(make_sample(SYM_LATE, i == 7));
      end
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               carrier_inc = 32'd0;
               second_inc  = 32'd1;
            end
            1: begin
               carrier_inc = INCREMENT_MAX;
               second_inc  = INCREMENT_MAX;
            end
            2: begin
               carrier_inc = 32'd1;
               second_inc  = 32'd0;
            end
            default: begin
               carrier_inc = $urandom_range(INCREMENT_MAX, 0);
               second_inc  = $urandom_range(SECOND_FULL / 8, SECOND_FULL / 64);
            end
         endcase
         configure(carrier_inc, second_inc);
         steady <= (p == 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_sample(random_sample());
         end
         drain();
         steady <= 1'b0;
      end

      $display("sent %0d sample ticks over %0d register settings, %0d results compared",
               sent_count, setting_count, checked_count);
      $display("%0d of them had the carrier keyed off", gated_count);
      if (error_count == 0 && pending == 0) begin
         $display("time_signal_keyed_carrier_fir test passed");
      end else begin
         $display("time_signal_keyed_carrier_fir test failed");
      end
      $finish;
   end

endmodule
